/* src/flexpage_order_select_macros.svh */
// assertion macros for the flexpage order select modules, used by fos_encode
`ifndef FLEXPAGE_ORDER_SELECT_MACROS_SVH
`define FLEXPAGE_ORDER_SELECT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FOS_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FOS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fos_pkg.sv */
// constants, stage types and helpers for the flexpage order select block
package fos_pkg;

    localparam int ADDR_W     = 48;
    localparam int BASE_ORDER = 12;
    localparam int MAX_ORDER  = 30;
    localparam int SUM_W      = ADDR_W + 1;
    localparam int FLAG_W     = 8;
    localparam int ORD_W      = 5;
    localparam int BOFF_W     = 30;
    localparam int NUM_ORD    = MAX_ORDER - BASE_ORDER;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_W      = ADDR_W;

    localparam logic [SUM_W-1:0] PAGE_MASK = ~({SUM_W{1'b1}} << BASE_ORDER);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_REGION_BASE = 2'd0,
        REG_REGION_SIZE = 2'd1,
        REG_FLAGS_MASK  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] region_base;
        logic [ADDR_W-1:0] region_size;
        logic [FLAG_W-1:0] flags_mask;
    } cfg_t;

    // after stage 1: access address and rounded region size
    typedef struct packed {
        logic              range_err;
        logic [SUM_W-1:0]  adr;
        logic [SUM_W-1:0]  rounded;
        logic [ADDR_W-1:0] base;
        logic              hs_valid;
        logic [ADDR_W-1:0] hot;
        logic [ADDR_W-1:0] wlo;
        logic [ADDR_W-1:0] whi;
        logic [FLAG_W-1:0] gflags;
    } s1_t;

    // after stage 2: inclusive region end
    typedef struct packed {
        logic              range_err;
        logic [SUM_W-1:0]  adr;
        logic [SUM_W-1:0]  region_end;
        logic [ADDR_W-1:0] base;
        logic              hs_valid;
        logic [ADDR_W-1:0] hot;
        logic [ADDR_W-1:0] wlo;
        logic [ADDR_W-1:0] whi;
        logic [FLAG_W-1:0] gflags;
    } s2_t;

    // after stage 3: one pass bit per candidate order above the page
    typedef struct packed {
        logic               range_err;
        logic [SUM_W-1:0]   adr;
        logic [NUM_ORD-1:0] pass;
        logic [FLAG_W-1:0]  gflags;
    } s3_t;

    typedef struct packed {
        logic              range_error;
        logic [ADDR_W-1:0] block_base;
        logic [ORD_W-1:0]  map_order;
        logic [FLAG_W-1:0] granted_flags;
        logic [BOFF_W-1:0] block_offset;
    } rsp_t;

    // ones below bit ord
    function automatic logic [SUM_W-1:0] low_mask(input logic [ORD_W-1:0] ord);
        return ~({SUM_W{1'b1}} << ord);
    endfunction

endpackage

/* src/fos_if.sv */
// request and response channel interfaces
interface fos_req_if import fos_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ADDR_W-1:0] offset;
    logic [FLAG_W-1:0] access_flags;
    logic              hint_valid;
    logic [ADDR_W-1:0] hint_addr;
    logic [ADDR_W-1:0] window_low;
    logic [ADDR_W-1:0] window_high;

    modport source (
        output valid, offset, access_flags, hint_valid, hint_addr, window_low,
               window_high,
        input  ready
    );
    modport sink (
        input  valid, offset, access_flags, hint_valid, hint_addr, window_low,
               window_high,
        output ready
    );
endinterface

interface fos_rsp_if import fos_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              range_error;
    logic [ADDR_W-1:0] block_base;
    logic [ORD_W-1:0]  map_order;
    logic [FLAG_W-1:0] granted_flags;
    logic [BOFF_W-1:0] block_offset;

    modport source (
        output valid, range_error, block_base, map_order, granted_flags, block_offset,
        input  ready
    );
    modport sink (
        input  valid, range_error, block_base, map_order, granted_flags, block_offset,
        output ready
    );
endinterface

/* src/flexpage_order_select.sv */
// top level of the flexpage order select block
//
// req channel: one fault request per accepted handshake (offset, access
// flags, optional hint address, receiver window). rsp channel: one result
// per request, in request order: range error, block base, order, granted
// flags, offset in the block.
// cfg port: cfg_we writes cfg_wdata into register cfg_index (0 region base,
// 1 region size, 2 flags mask). The user must write only while no request
// is in flight; the block does not check this. Stages: address add, region
// end add, per-order tests, order encode into the output register. The rate
// is one request per cycle while results are taken; every candidate order
// is tested in parallel in one stage, so the tests set no iteration limit.
// Reset clears all stage valid bits, sets region base and size to zero and
// the flags mask to all ones.
// When the receiver stalls, the output register holds its result and each
// stage keeps its item; req.ready falls once every stage is full, and
// empty stages still fill behind a stalled output.
module flexpage_order_select import fos_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    fos_req_if.sink              req,
    fos_rsp_if.source            rsp
);

    logic [ADDR_W-1:0] region_base_reg, region_base_next;
    logic [ADDR_W-1:0] region_size_reg, region_size_next;
    logic [FLAG_W-1:0] flags_mask_reg, flags_mask_next;
    cfg_t              cfg;

    logic s2_valid, s2_ready;
    s2_t  s2_data;
    logic s3_valid, s3_ready;
    s3_t  s3_data;

    always_comb
    begin
        region_base_next = region_base_reg;
        region_size_next = region_size_reg;
        flags_mask_next  = flags_mask_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_REGION_BASE: region_base_next = cfg_wdata[ADDR_W-1:0];
                REG_REGION_SIZE: region_size_next = cfg_wdata[ADDR_W-1:0];
                REG_FLAGS_MASK:  flags_mask_next  = cfg_wdata[FLAG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_base_reg <= '0;
            region_size_reg <= '0;
            flags_mask_reg  <= '1;
        end
        else
        begin
            region_base_reg <= region_base_next;
            region_size_reg <= region_size_next;
            flags_mask_reg  <= flags_mask_next;
        end
    end

    assign cfg.region_base = region_base_reg;
    assign cfg.region_size = region_size_reg;
    assign cfg.flags_mask  = flags_mask_reg;

    fos_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .req       (req),
        .out_valid (s2_valid),
        .out_ready (s2_ready),
        .out_data  (s2_data)
    );

    fos_test u_test (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s2_valid),
        .in_ready  (s2_ready),
        .in_data   (s2_data),
        .out_valid (s3_valid),
        .out_ready (s3_ready),
        .out_data  (s3_data)
    );

    fos_encode u_encode (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s3_valid),
        .in_ready (s3_ready),
        .in_data  (s3_data),
        .rsp      (rsp)
    );

endmodule

/* src/fos_prep.sv */
// stages 1 and 2: access address, range check and region end
module fos_prep import fos_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    fos_req_if.sink     req,
    output logic        out_valid,
    input  logic        out_ready,
    output s2_t         out_data
);

    logic s1_v_reg, s1_v_next;
    logic s2_v_reg, s2_v_next;
    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    logic s1_ready, s2_ready;

    assign s2_ready  = !s2_v_reg || out_ready;
    assign s1_ready  = !s1_v_reg || s2_ready;
    assign req.ready = s1_ready;

    always_comb
    begin
        s1_next.range_err = req.offset >= cfg.region_size;
        s1_next.adr       = {1'b0, cfg.region_base} + {1'b0, req.offset};
        s1_next.rounded   = ({1'b0, cfg.region_size} + PAGE_MASK) & ~PAGE_MASK;
        s1_next.base      = cfg.region_base;
        s1_next.hs_valid  = req.hint_valid;
        s1_next.hot       = req.hint_addr;
        s1_next.wlo       = req.window_low & ~PAGE_MASK[ADDR_W-1:0];
        s1_next.whi       = req.window_high;
        s1_next.gflags    = req.access_flags & cfg.flags_mask;
    end

    always_comb
    begin
        s2_next.range_err  = s1_reg.range_err;
        s2_next.adr        = s1_reg.adr;
        // inclusive end, rounded is at least one page when no range error
        s2_next.region_end = {1'b0, s1_reg.base} + s1_reg.rounded - SUM_W'(1);
        s2_next.base       = s1_reg.base;
        s2_next.hs_valid   = s1_reg.hs_valid;
        s2_next.hot        = s1_reg.hot;
        s2_next.wlo        = s1_reg.wlo;
        s2_next.whi        = s1_reg.whi;
        s2_next.gflags     = s1_reg.gflags;
    end

    assign s1_v_next = s1_ready ? req.valid : s1_v_reg;
    assign s2_v_next = s2_ready ? s1_v_reg : s2_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= s1_v_next;
            s2_v_reg <= s2_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && req.valid)
        begin
            s1_reg <= s1_next;
        end
        if (s2_ready && s1_v_reg)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = s2_v_reg;
    assign out_data  = s2_reg;

endmodule

/* src/fos_test.sv */
// stage 3: the five block tests for every candidate order in parallel
module fos_test import fos_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  s2_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output s3_t  out_data
);

    logic s3_v_reg, s3_v_next;
    s3_t  s3_reg, s3_next;

    assign in_ready  = !s3_v_reg || out_ready;
    assign s3_v_next = in_ready ? in_valid : s3_v_reg;

    always_comb
    begin
        logic [SUM_W-1:0] mask;
        logic [SUM_W-1:0] hot_x;
        logic             src_ok;
        logic             end_ok;
        logic             lo_ok;
        logic             hi_ok;
        logic             hs_ok;
        s3_next.range_err = in_data.range_err;
        s3_next.adr       = in_data.adr;
        s3_next.gflags    = in_data.gflags;
        hot_x             = {1'b0, in_data.hot};
        for (int i = 0; i < NUM_ORD; i++)
        begin
            // candidate order is BASE_ORDER + 1 + i; aligned block end is addr | mask
            mask   = low_mask(ORD_W'(BASE_ORDER + 1 + i));
            src_ok = (in_data.adr & ~mask) >= {1'b0, in_data.base};
            end_ok = (in_data.adr | mask) <= in_data.region_end;
            lo_ok  = (hot_x & ~mask) >= {1'b0, in_data.wlo};
            hi_ok  = (hot_x | mask) <= {1'b0, in_data.whi};
            hs_ok  = in_data.hs_valid && (((in_data.adr ^ hot_x) & mask) == '0);
            s3_next.pass[i] = src_ok && end_ok && lo_ok && hi_ok && hs_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_v_reg <= 1'b0;
        end
        else
        begin
            s3_v_reg <= s3_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s3_reg <= s3_next;
        end
    end

    assign out_valid = s3_v_reg;
    assign out_data  = s3_reg;

endmodule

/* src/fos_encode.sv */
// stage 4: order from the run of passing tests, output register
`include "flexpage_order_select_macros.svh"

module fos_encode import fos_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  s3_t      in_data,
    fos_rsp_if.source rsp
);

    logic rsp_v_reg, rsp_v_next;
    rsp_t rsp_reg, rsp_next;

    assign in_ready   = !rsp_v_reg || rsp.ready;
    assign rsp_v_next = in_ready ? in_valid : rsp_v_reg;

    always_comb
    begin
        logic [NUM_ORD-1:0] pref;
        logic [NUM_ORD-1:0] m;
        logic [NUM_ORD-1:0] top;
        logic [ORD_W-1:0]   ord;
        logic [SUM_W-1:0]   mask;
        // the search stops at the first failing order: find the leading run
        for (int i = 0; i < NUM_ORD; i++)
        begin
            m       = ~({NUM_ORD{1'b1}} << (i + 1));
            pref[i] = (in_data.pass & m) == m;
        end
        // pref is a thermometer code, its top set bit picks the order
        top = pref & ~(pref >> 1);
        ord = (top == '0) ? ORD_W'(BASE_ORDER) : '0;
        for (int i = 0; i < NUM_ORD; i++)
        begin
            ord = ord | (top[i] ? ORD_W'(BASE_ORDER + 1 + i) : ORD_W'(0));
        end
        mask = low_mask(ord);
        if (in_data.range_err)
        begin
            rsp_next = '0;
            rsp_next.range_error = 1'b1;
        end
        else
        begin
            rsp_next.range_error   = 1'b0;
            rsp_next.block_base    = ADDR_W'(in_data.adr & ~mask);
            rsp_next.map_order     = ord;
            rsp_next.granted_flags = in_data.gflags;
            rsp_next.block_offset  = BOFF_W'(in_data.adr & mask);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_v_reg <= 1'b0;
        end
        else
        begin
            rsp_v_reg <= rsp_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp.valid         = rsp_v_reg;
    assign rsp.range_error   = rsp_reg.range_error;
    assign rsp.block_base    = rsp_reg.block_base;
    assign rsp.map_order     = rsp_reg.map_order;
    assign rsp.granted_flags = rsp_reg.granted_flags;
    assign rsp.block_offset  = rsp_reg.block_offset;

    `FOS_ASSERT_IMP(a_err_zero, rsp.valid && rsp.range_error,
        rsp.block_base == '0 && rsp.map_order == '0 && rsp.granted_flags == '0 &&
        rsp.block_offset == '0, "range error with nonzero fields")
    `FOS_ASSERT_IMP(a_order_range, rsp.valid && !rsp.range_error,
        rsp.map_order >= ORD_W'(BASE_ORDER) && rsp.map_order <= ORD_W'(MAX_ORDER),
        "order outside base page and max order")
    `FOS_ASSERT_IMP(a_base_aligned, rsp.valid && !rsp.range_error,
        (SUM_W'(rsp.block_base) & low_mask(rsp.map_order)) == '0,
        "block base not aligned to order")
    `FOS_ASSERT_IMP(a_boff_fits, rsp.valid && !rsp.range_error,
        (SUM_W'(rsp.block_offset) & ~low_mask(rsp.map_order)) == '0,
        "block offset exceeds block size")
    `FOS_ASSERT_NEXT(a_load_valid, in_valid && in_ready, rsp.valid,
        "accepted stage data did not reach the output register")

endmodule

/* test/flexpage_order_select_tb.sv */
// self-checking testbench for the flexpage order select block
module flexpage_order_select_tb;
    import fos_pkg::*;

    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          CALM_TAIL      = 80;
    localparam logic [47:0] TOP48          = 48'hFFFF_FFFF_FFFF;
    localparam bit [63:0]   TOP64          = 64'h0000_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [FLAG_W-1:0] access_flags;
        logic              hint_valid;
        logic [ADDR_W-1:0] hint_addr;
        logic [ADDR_W-1:0] window_low;
        logic [ADDR_W-1:0] window_high;
    } fault_req_t;

    // one planned operation: a register write or a fault request
    typedef struct {
        bit               is_write;
        cfg_reg_t         reg_idx;
        logic [CFG_W-1:0] wdata;
        fault_req_t       fault;
    } plan_entry_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    fos_req_if req_ch ();
    fos_rsp_if rsp_ch ();

    flexpage_order_select u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    plan_entry_t       pending_ops[$];
    rsp_t              expected_maps[$];
    logic [ADDR_W-1:0] mdl_base  = '0;
    logic [ADDR_W-1:0] mdl_size  = '0;
    logic [FLAG_W-1:0] mdl_fmask = '1;
    bit                req_took  = 1'b0;
    bit                calm      = 1'b0;
    int                src_gap   = 0;
    int                sink_hold = 0;
    int                idle_cycles = 0;
    int                mismatches  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic bit [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [47:0] rand48();
        return 48'(rand64());
    endfunction

    // largest aligned block that passes the region, window and hint tests
    function automatic rsp_t predict_mapping(fault_req_t f, logic [ADDR_W-1:0] rb,
                                             logic [ADDR_W-1:0] rs,
                                             logic [FLAG_W-1:0] fm);
        rsp_t      r;
        bit [63:0] base64, rounded, rend, adr, wlo, whi, hot, span, src, hb, low;
        int        ord;
        bit        grow;
        r = '0;
        if (f.offset >= rs)
        begin
            r.range_error = 1'b1;
            return r;
        end
        base64  = {16'd0, rb};
        rounded = ({16'd0, rs} + 64'hFFF) & ~64'hFFF;
        rend    = base64 + rounded - 64'd1;
        wlo     = {16'd0, f.window_low} & ~64'hFFF;
        whi     = {16'd0, f.window_high};
        hot     = {16'd0, f.hint_addr};
        adr     = base64 + {16'd0, f.offset};
        ord     = BASE_ORDER;
        grow    = 1'b1;
        while (grow && ord < MAX_ORDER)
        begin
            span = 64'd1 << (ord + 1);
            src  = adr & ~(span - 64'd1);
            hb   = hot & ~(span - 64'd1);
            grow = (src >= base64) && (src + span - 64'd1 <= rend) &&
                   (hb >= wlo) && (hb + span - 64'd1 <= whi) &&
                   f.hint_valid && (((adr ^ hot) & (span - 64'd1)) == 64'd0);
            if (grow)
                ord++;
        end
        low             = (64'd1 << ord) - 64'd1;
        r.block_base    = 48'(adr & ~low);
        r.map_order     = 5'(ord);
        r.granted_flags = f.access_flags & fm;
        r.block_offset  = 30'(adr & low);
        return r;
    endfunction

    function automatic fault_req_t make_fault(logic [47:0] off, logic [7:0] fl, logic hv,
                                              logic [47:0] hot, logic [47:0] lo,
                                              logic [47:0] hi);
        fault_req_t f;
        f.offset       = off;
        f.access_flags = fl;
        f.hint_valid   = hv;
        f.hint_addr    = hot;
        f.window_low   = lo;
        f.window_high  = hi;
        return f;
    endfunction

    // hint shares low bits with the access, window built around its block
    function automatic fault_req_t shaped_fault(logic [47:0] rb, logic [47:0] rs);
        fault_req_t f;
        bit [63:0]  adr, kmask, jmask, blk, lo, hi;
        int         k, j;
        f.access_flags = 8'($urandom);
        f.hint_valid   = ($urandom_range(0, 9) != 0);
        if (rs == 0)
            f.offset = rand48();
        else if ($urandom_range(0, 7) == 0)
            f.offset = rs - 48'(1 + ($urandom_range(0, 8191) % {16'd0, rs}));
        else
            f.offset = 48'(rand64() % {16'd0, rs});
        adr   = {16'd0, rb} + {16'd0, f.offset};
        k     = $urandom_range(BASE_ORDER, MAX_ORDER + 1);
        kmask = (64'd1 << k) - 64'd1;
        f.hint_addr = 48'(({16'd0, rand48()} & ~kmask) | (adr & kmask));
        j     = $urandom_range(BASE_ORDER, MAX_ORDER + 2);
        jmask = (64'd1 << j) - 64'd1;
        blk   = {16'd0, f.hint_addr} & ~jmask;
        lo    = blk;
        hi    = blk + jmask;
        if ($urandom_range(0, 3) == 0)
            lo = (blk > 64'd8191) ? blk - $urandom_range(0, 8191) : 64'd0;
        else if ($urandom_range(0, 3) == 0)
            lo = lo + $urandom_range(0, 4095);
        if ($urandom_range(0, 3) == 0)
            hi = hi + $urandom_range(0, 8191);
        else if ($urandom_range(0, 5) == 0 && hi >= 64'd4096)
            hi = hi - $urandom_range(1, 4096);
        if (hi > TOP64)
            hi = TOP64;
        f.window_low  = 48'(lo);
        f.window_high = 48'(hi);
        return f;
    endfunction

    function automatic fault_req_t noise_fault(logic [47:0] rs);
        fault_req_t f;
        if (rs == 0 || $urandom_range(0, 1) == 0)
            f.offset = rand48();
        else
            f.offset = 48'(rand64() % {16'd0, rs});
        f.access_flags = 8'($urandom);
        f.hint_valid   = 1'($urandom_range(0, 1));
        f.hint_addr    = rand48();
        f.window_low   = rand48();
        f.window_high  = rand48();
        return f;
    endfunction

    task automatic plan_write(cfg_reg_t idx, logic [CFG_W-1:0] value);
        plan_entry_t e;
        e.is_write = 1'b1;
        e.reg_idx  = idx;
        e.wdata    = value;
        e.fault    = '0;
        pending_ops.push_back(e);
    endtask

    task automatic plan_fault(fault_req_t f);
        plan_entry_t e;
        e.is_write = 1'b0;
        e.reg_idx  = REG_REGION_BASE;
        e.wdata    = '0;
        e.fault    = f;
        pending_ops.push_back(e);
    endtask

    task automatic plan_random_phase(int n);
        int          a, sb;
        logic [47:0] rb, rs, mw;
        a  = $urandom_range(BASE_ORDER, 40);
        rb = rand48() & ~((48'd1 << a) - 48'd1);
        if ($urandom_range(0, 4) == 0)
            rb = rand48();
        sb = ($urandom_range(0, 1) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 40);
        rs = rand48() & ((48'd1 << sb) - 48'd1);
        if ($urandom_range(0, 7) == 0)
            rs = TOP48 - $urandom_range(0, 255);
        mw = rand48();
        case ($urandom_range(0, 3))
            0: mw[7:0] = 8'h00;
            1: mw[7:0] = 8'hFF;
            default: ;
        endcase
        plan_write(REG_REGION_BASE, rb);
        plan_write(REG_REGION_SIZE, rs);
        plan_write(REG_FLAGS_MASK, mw);
        repeat (n)
        begin
            if ($urandom_range(0, 3) != 0)
                plan_fault(shaped_fault(rb, rs));
            else
                plan_fault(noise_fault(rs));
        end
    endtask

    // request driver and config writer
    always @(negedge clk)
    begin
        bit hold_valid;
        bit wr;
        if (rst_n)
        begin
            hold_valid = req_ch.valid && !req_took;
            wr = 1'b0;
            if (!hold_valid)
            begin
                if (src_gap > 0)
                    src_gap--;
                else if (pending_ops.size() > 0)
                begin
                    if (pending_ops[0].is_write)
                    begin
                        // registers change only once the pipe has drained
                        if (expected_maps.size() == 0)
                        begin
                            cfg_index <= pending_ops[0].reg_idx;
                            cfg_wdata <= pending_ops[0].wdata;
                            wr = 1'b1;
                            void'(pending_ops.pop_front());
                        end
                    end
                    else
                    begin
                        req_ch.offset       <= pending_ops[0].fault.offset;
                        req_ch.access_flags <= pending_ops[0].fault.access_flags;
                        req_ch.hint_valid   <= pending_ops[0].fault.hint_valid;
                        req_ch.hint_addr    <= pending_ops[0].fault.hint_addr;
                        req_ch.window_low   <= pending_ops[0].fault.window_low;
                        req_ch.window_high  <= pending_ops[0].fault.window_high;
                        hold_valid = 1'b1;
                        void'(pending_ops.pop_front());
                        if (!calm && $urandom_range(0, 5) == 0)
                            src_gap = $urandom_range(1, 15);
                    end
                end
            end
            req_ch.valid <= hold_valid;
            cfg_we <= wr;
        end
    end

    // response backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (sink_hold > 0)
            begin
                sink_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                sink_hold = $urandom_range(0, 14);
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // monitor: config shadow, prediction on request, check on result
    always @(posedge clk)
    begin
        rsp_t       want;
        fault_req_t seen;
        bit         rsp_took;
        req_took = 1'b0;
        if (rst_n)
        begin
            calm = (pending_ops.size() <= CALM_TAIL);
            rsp_took = rsp_ch.valid && rsp_ch.ready;
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_REGION_BASE: mdl_base  = cfg_wdata;
                    REG_REGION_SIZE: mdl_size  = cfg_wdata;
                    REG_FLAGS_MASK:  mdl_fmask = cfg_wdata[FLAG_W-1:0];
                    default: ;
                endcase
            end
            if (rsp_took)
            begin
                if (expected_maps.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: err %0d base %h order %0d flags %h off %h",
                                 rsp_ch.range_error, rsp_ch.block_base, rsp_ch.map_order,
                                 rsp_ch.granted_flags, rsp_ch.block_offset);
                end
                else
                begin
                    want = expected_maps.pop_front();
                    if (rsp_ch.range_error !== want.range_error ||
                        rsp_ch.block_base !== want.block_base ||
                        rsp_ch.map_order !== want.map_order ||
                        rsp_ch.granted_flags !== want.granted_flags ||
                        rsp_ch.block_offset !== want.block_offset)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("mismatch: expected err %0d base %h order %0d flags %h off %h",
                                     want.range_error, want.block_base, want.map_order,
                                     want.granted_flags, want.block_offset);
                            $display("          actual   err %0d base %h order %0d flags %h off %h",
                                     rsp_ch.range_error, rsp_ch.block_base, rsp_ch.map_order,
                                     rsp_ch.granted_flags, rsp_ch.block_offset);
                        end
                    end
                end
            end
            if (req_ch.valid && req_ch.ready)
            begin
                req_took = 1'b1;
                seen.offset       = req_ch.offset;
                seen.access_flags = req_ch.access_flags;
                seen.hint_valid   = req_ch.hint_valid;
                seen.hint_addr    = req_ch.hint_addr;
                seen.window_low   = req_ch.window_low;
                seen.window_high  = req_ch.window_high;
                expected_maps.push_back(predict_mapping(seen, mdl_base, mdl_size, mdl_fmask));
            end
            if (req_took || rsp_took || cfg_we)
                idle_cycles = 0;
            else
            begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT)
                begin
                    $display("** flexpage_order_select: FAILED **");
                    $finish;
                end
            end
        end
    end

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = REG_REGION_BASE;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.offset       = '0;
        req_ch.access_flags = '0;
        req_ch.hint_valid   = 1'b0;
        req_ch.hint_addr    = '0;
        req_ch.window_low   = '0;
        req_ch.window_high  = '0;
        rsp_ch.ready        = 1'b0;

        // reset values: empty region, every request is out of range
        plan_fault(make_fault(48'h0, 8'hFF, 1'b1, 48'h0, 48'h0, TOP48));
        plan_fault(make_fault(TOP48, 8'h00, 1'b0, TOP48, TOP48, 48'h0));

        plan_write(REG_REGION_BASE, 48'h0);
        plan_write(REG_REGION_SIZE, 48'h0100_0000_0000);
        plan_write(REG_FLAGS_MASK, 48'hA5);
        // no hint keeps the base page
        plan_fault(make_fault(48'h0, 8'h00, 1'b0, 48'h0, 48'h0, TOP48));
        plan_fault(make_fault(48'h0, 8'hFF, 1'b1, 48'h0, 48'h0, TOP48));
        plan_fault(make_fault(48'h1234_5000, 8'h3C, 1'b1, 48'h1234_4000, 48'h0, TOP48));
        plan_fault(make_fault(48'h1234_5000, 8'hC3, 1'b1, 48'h1224_5000, 48'h0, TOP48));
        plan_fault(make_fault(48'h00FF_FFFF_FFFF, 8'h5A, 1'b1, 48'h00FF_FFFF_FFFF,
                              48'h0, TOP48));
        plan_fault(make_fault(48'h0100_0000_0000, 8'hFF, 1'b1, 48'h0, 48'h0, TOP48));
        plan_fault(make_fault(TOP48, 8'hFF, 1'b1, TOP48, 48'h0, TOP48));
        // inverted and empty windows
        plan_fault(make_fault(48'h8000_0000, 8'h01, 1'b1, 48'h8000_0000, TOP48, 48'h0));
        plan_fault(make_fault(48'h8000_0000, 8'h80, 1'b1, 48'h8000_0000, 48'h8000_0000,
                              48'h8000_0000));
        // window low inside a page is truncated
        plan_fault(make_fault(48'h4000_0000, 8'h7E, 1'b1, 48'h4000_0000, 48'h4000_0FFF,
                              TOP48));
        plan_fault(make_fault(48'h3FFF_FFFF, 8'hFF, 1'b1, TOP48, 48'h0, TOP48));

        plan_write(REG_REGION_BASE, 48'h7FFF_C000_0000);
        plan_write(REG_REGION_SIZE, 48'h0000_C000_0005);
        plan_write(REG_FLAGS_MASK, 48'h0);
        plan_fault(make_fault(48'h0, 8'hFF, 1'b1, 48'h1234_0000_0000, 48'h0, TOP48));
        plan_fault(make_fault(48'hC000_0004, 8'hFF, 1'b1, 48'h8000_8000_0004, 48'h0, TOP48));
        plan_fault(make_fault(48'hC000_0005, 8'hFF, 1'b1, 48'h0, 48'h0, TOP48));

        // address sums run past 48 bits
        plan_write(REG_REGION_BASE, TOP48);
        plan_write(REG_REGION_SIZE, TOP48);
        plan_write(REG_FLAGS_MASK, TOP48);
        plan_fault(make_fault(48'h0, 8'h96, 1'b1, TOP48, 48'h0, TOP48));
        plan_fault(make_fault(TOP48 - 48'd1, 8'h69, 1'b1, TOP48 - 48'd2, 48'h0, TOP48));
        plan_fault(make_fault(TOP48, 8'hFF, 1'b1, TOP48, 48'h0, TOP48));

        repeat (6)
            plan_random_phase(105);

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (!(pending_ops.size() == 0 && !req_ch.valid && expected_maps.size() == 0))
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (mismatches == 0)
            $display("** flexpage_order_select: PASSED **");
        else
            $display("** flexpage_order_select: FAILED **");
        $finish;
    end

endmodule
